@@ src/sabc_pkg.sv @@
// shared types, constants and spot arithmetic for the scaled alpha blend compositor
package sabc_pkg;

   localparam int MAX_COLS   = 256;
   localparam int MAX_ROWS   = 256;
   localparam int MAX_REPEAT = 8;

   localparam int COL_BITS   = $clog2(MAX_COLS);
   localparam int ROW_BITS   = $clog2(MAX_ROWS);
   localparam int ADDR_BITS  = COL_BITS + ROW_BITS;
   localparam int DEPTH      = MAX_COLS * MAX_ROWS;
   localparam int PIX_BITS   = 24;
   localparam int REP_BITS   = 3;
   localparam int FRAC_BITS  = 21;
   localparam int LIM_BITS   = 9;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 11;

   localparam logic [CSR_IDX_BITS-1:0] REG_OFFSET_X    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_OFFSET_Y    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_ZOOM_X      = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_ZOOM_Y      = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_CANVAS_COLS = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_CANVAS_ROWS = 3'd5;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_BLEND
   } state_type;

   typedef struct packed {
      logic [10:0]         offset_x;
      logic [10:0]         offset_y;
      logic [10:0]         zoom_x;
      logic [10:0]         zoom_y;
      logic [LIM_BITS-1:0] canvas_cols;
      logic [LIM_BITS-1:0] canvas_rows;
   } cfg_type;

   typedef struct packed {
      logic                 load;
      logic                 clear;
      logic                 rd_en;
      logic                 wr_en;
      logic                 emit;
      logic                 final_write;
      logic [ADDR_BITS-1:0] addr;
   } ctl_type;

   typedef struct packed {
      logic       on_canvas;
      logic [7:0] pos;
   } axis_type;

   // trunc toward zero of (whole*256 + frac)/256, then bounds check against lim
   function automatic axis_type spot_axis(input logic [12:0] whole,
                                          input logic [FRAC_BITS-1:0] frac,
                                          input logic [LIM_BITS-1:0] lim);
      logic [23:0] s;
      axis_type    r;
      s = {{3{whole[12]}}, whole, 8'd0} + {3'd0, frac};
      if (s[23]) begin
         r.on_canvas = (&s[23:8]) && (s[7:0] != 8'd0) && (lim != '0);
         r.pos       = 8'd0;
      end else begin
         r.on_canvas = (s[23:8] < {7'd0, lim});
         r.pos       = s[15:8];
      end
      return r;
   endfunction

   // repeat count minus one: ceil(z/256) held to 1..MAX_REPEAT
   function automatic logic [REP_BITS-1:0] rep_last(input logic [10:0] z);
      logic [11:0] t;
      logic [3:0]  n;
      t = {1'b0, z} + 12'd255;
      n = t[11:8];
      if (n == 4'd0) n = 4'd1;
      if (n > 4'(MAX_REPEAT)) n = 4'(MAX_REPEAT);
      return REP_BITS'(n - 4'd1);
   endfunction

   // clamp a canvas size register to the store size
   function automatic logic [LIM_BITS-1:0] clamp_lim(input logic [LIM_BITS-1:0] v,
                                                     input logic [LIM_BITS-1:0] top);
      return (v > top) ? top : v;
   endfunction

endpackage

@@ src/sabc_ram.sv @@
// generic single-port-address synchronous ram with registered read
module sabc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/sabc_blend.sv @@
// per-channel alpha blend (new*a + old*(255-a))/255 over three color lanes
module sabc_blend (
   input  logic [sabc_pkg::PIX_BITS-1:0] new_rgb,
   input  logic [sabc_pkg::PIX_BITS-1:0] old_rgb,
   input  logic [7:0]                    alpha,
   output logic [sabc_pkg::PIX_BITS-1:0] mix_rgb
);

   for (genvar c = 0; c < 3; c++) begin : g_lane
      logic [7:0]         n_val;
      logic [7:0]         o_val;
      logic signed [8:0]  diff;
      logic signed [17:0] prod;
      logic [15:0]        base;
      logic [15:0]        sum;
      logic [15:0]        adj;

      assign n_val = new_rgb[8*c +: 8];
      assign o_val = old_rgb[8*c +: 8];
      assign diff  = $signed({1'b0, n_val}) - $signed({1'b0, o_val});
      assign prod  = diff * $signed({1'b0, alpha});
      // o*255 + (n-o)*a
      assign base  = {o_val, 8'd0} - {8'd0, o_val};
      assign sum   = base + prod[15:0];
      // exact divide by 255 for the sums that arise here, at most 255*255
      assign adj   = sum + 16'd1 + {8'd0, sum[15:8]};
      assign mix_rgb[8*c +: 8] = adj[15:8];
   end

endmodule

@@ src/sabc_seq.sv @@
// spot sequencer: canvas clear sweep, spot walk and read-modify-write control
module sabc_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  sabc_pkg::cfg_type        cfg,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [9:0]               req_src_x,
   input  logic [9:0]               req_src_y,
   input  logic                     rsp_free,
   output sabc_pkg::ctl_type        ctl
);

   sabc_pkg::state_type state_ff, state_in;

   logic [sabc_pkg::ADDR_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic [sabc_pkg::FRAC_BITS-1:0] fx_ff, fx_in;
   logic [sabc_pkg::FRAC_BITS-1:0] fy_ff, fy_in;
   logic [sabc_pkg::REP_BITS-1:0]  i_ff, i_in;
   logic [sabc_pkg::REP_BITS-1:0]  j_ff, j_in;
   logic [sabc_pkg::REP_BITS-1:0]  nx_last_ff, nx_last_in;
   logic [sabc_pkg::REP_BITS-1:0]  ny_last_ff, ny_last_in;
   logic [sabc_pkg::ADDR_BITS-1:0] spot_addr_ff, spot_addr_in;
   logic                           final_ff, final_in;

   logic [sabc_pkg::LIM_BITS-1:0] cols_eff;
   logic [sabc_pkg::LIM_BITS-1:0] rows_eff;
   logic [12:0]                   whole_x, whole_x1, whole_y, whole_y1;
   sabc_pkg::axis_type            ax, ax1, ay, ay1;
   logic                          hit, x_last, y_last, row_done, walk_done;
   logic                          clr_done, accept;

   assign cols_eff = sabc_pkg::clamp_lim(cfg.canvas_cols,
                                         sabc_pkg::LIM_BITS'(sabc_pkg::MAX_COLS));
   assign rows_eff = sabc_pkg::clamp_lim(cfg.canvas_rows,
                                         sabc_pkg::LIM_BITS'(sabc_pkg::MAX_ROWS));

   assign whole_x  = {{2{cfg.offset_x[10]}}, cfg.offset_x} + {10'd0, i_ff};
   assign whole_x1 = {{2{cfg.offset_x[10]}}, cfg.offset_x} + {9'd0, {1'b0, i_ff} + 4'd1};
   assign whole_y  = {{2{cfg.offset_y[10]}}, cfg.offset_y} + {10'd0, j_ff};
   assign whole_y1 = {{2{cfg.offset_y[10]}}, cfg.offset_y} + {9'd0, {1'b0, j_ff} + 4'd1};

   assign ax  = sabc_pkg::spot_axis(whole_x, fx_ff, cols_eff);
   assign ax1 = sabc_pkg::spot_axis(whole_x1, fx_ff, cols_eff);
   assign ay  = sabc_pkg::spot_axis(whole_y, fy_ff, rows_eff);
   assign ay1 = sabc_pkg::spot_axis(whole_y1, fy_ff, rows_eff);

   // spots grow monotonically with the index, so on-canvas spots form one run per axis
   assign hit       = ax.on_canvas && ay.on_canvas;
   assign x_last    = (i_ff == nx_last_ff) || !ax1.on_canvas;
   assign y_last    = (j_ff == ny_last_ff) || !ay1.on_canvas;
   assign row_done  = (j_ff == ny_last_ff) || !ax.on_canvas;
   assign walk_done = (i_ff == nx_last_ff) && row_done;
   assign clr_done  = (clr_addr_ff == sabc_pkg::ADDR_BITS'(sabc_pkg::DEPTH - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sabc_pkg::ST_CLEAR: begin
            if (clr_done) state_in = sabc_pkg::ST_IDLE;
         end
         sabc_pkg::ST_IDLE: begin
            if (req_valid) state_in = sabc_pkg::ST_SCAN;
         end
         sabc_pkg::ST_SCAN: begin
            if (hit) begin
               state_in = sabc_pkg::ST_BLEND;
            end else if (walk_done) begin
               state_in = sabc_pkg::ST_IDLE;
            end
         end
         sabc_pkg::ST_BLEND: begin
            if (rsp_free) begin
               if (!final_ff) begin
                  state_in = sabc_pkg::ST_SCAN;
               end else if (req_valid) begin
                  state_in = sabc_pkg::ST_SCAN;
               end else begin
                  state_in = sabc_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = sabc_pkg::ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      req_stall       = 1'b1;
      ctl.load        = 1'b0;
      ctl.clear       = 1'b0;
      ctl.rd_en       = 1'b0;
      ctl.wr_en       = 1'b0;
      ctl.emit        = 1'b0;
      ctl.final_write = final_ff;
      ctl.addr        = spot_addr_ff;
      case (state_ff)
         sabc_pkg::ST_CLEAR: begin
            ctl.clear = 1'b1;
            ctl.wr_en = 1'b1;
            ctl.addr  = clr_addr_ff;
         end
         sabc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            ctl.load  = req_valid;
         end
         sabc_pkg::ST_SCAN: begin
            ctl.rd_en = hit;
            ctl.addr  = {ay.pos, ax.pos};
         end
         sabc_pkg::ST_BLEND: begin
            ctl.wr_en = rsp_free;
            ctl.emit  = rsp_free;
            req_stall = !(rsp_free && final_ff);
            ctl.load  = rsp_free && final_ff && req_valid;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign accept = ctl.load;

   // walk counters and item registers
   always_comb begin
      clr_addr_in  = clr_addr_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      nx_last_in   = nx_last_ff;
      ny_last_in   = ny_last_ff;
      spot_addr_in = spot_addr_ff;
      final_in     = final_ff;
      if (state_ff == sabc_pkg::ST_CLEAR) begin
         clr_addr_in = clr_addr_ff + sabc_pkg::ADDR_BITS'(1);
      end
      if (state_ff == sabc_pkg::ST_SCAN) begin
         if (row_done) begin
            i_in = i_ff + sabc_pkg::REP_BITS'(1);
            j_in = '0;
         end else begin
            j_in = j_ff + sabc_pkg::REP_BITS'(1);
         end
         if (hit) begin
            spot_addr_in = {ay.pos, ax.pos};
            final_in     = x_last && y_last;
         end
      end
      if (accept) begin
         fx_in      = sabc_pkg::FRAC_BITS'(req_src_x) * sabc_pkg::FRAC_BITS'(cfg.zoom_x);
         fy_in      = sabc_pkg::FRAC_BITS'(req_src_y) * sabc_pkg::FRAC_BITS'(cfg.zoom_y);
         i_in       = '0;
         j_in       = '0;
         nx_last_in = sabc_pkg::rep_last(cfg.zoom_x);
         ny_last_in = sabc_pkg::rep_last(cfg.zoom_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sabc_pkg::ST_CLEAR;
         clr_addr_ff <= '0;
         i_ff        <= '0;
         j_ff        <= '0;
         final_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         i_ff        <= i_in;
         j_ff        <= j_in;
         final_ff    <= final_in;
      end
   end

   always_ff @(posedge clock) begin
      fx_ff        <= fx_in;
      fy_ff        <= fy_in;
      nx_last_ff   <= nx_last_in;
      ny_last_ff   <= ny_last_in;
      spot_addr_ff <= spot_addr_in;
   end

endmodule

@@ src/scaled_alpha_blend_compositor.sv @@
// top level of the scaled alpha blend compositor
// Usage: each transfer on the req_ channel carries one layer pixel (coordinates
// and RGBA). The block walks a block of up to 8 by 8 canvas spots for it, reads
// each spot inside the canvas from a 256x256 RGB store, blends the pixel over it,
// writes it back and sends one rsp_ transfer per write; rsp_final_write marks the
// last write of a pixel. A pixel whose spots all miss the canvas gives no transfer.
// Timing: each spot inside the canvas costs a store read in the scan state, then
// blend and write back in the blend state, and each spot outside it a scan step;
// one memory port sets this. At a scale of one or less a pixel has a single spot,
// and the next pixel is taken in the cycle that writes the last spot.
// Configuration: csr_ writes are always taken (csr_ready is high) and must only
// be issued while the block is idle.
// Reset: control and configuration registers return to defaults and the store is
// swept to black, one entry per cycle, while req_stall stays high.
// Stall: a result waits in the output register while rsp_stall is high; the
// sequencer holds its current write until that register frees up.
module scaled_alpha_blend_compositor (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [9:0]                        req_src_x,
   input  logic [9:0]                        req_src_y,
   input  logic [7:0]                        req_src_red,
   input  logic [7:0]                        req_src_green,
   input  logic [7:0]                        req_src_blue,
   input  logic [7:0]                        req_src_alpha,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_dst_x,
   output logic [7:0]                        rsp_dst_y,
   output logic [7:0]                        rsp_out_red,
   output logic [7:0]                        rsp_out_green,
   output logic [7:0]                        rsp_out_blue,
   output logic                              rsp_final_write,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sabc_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [sabc_pkg::CSR_DATA_BITS-1:0] csr_data
);

   sabc_pkg::cfg_type cfg_ff, cfg_in;
   sabc_pkg::ctl_type ctl;

   logic [sabc_pkg::PIX_BITS-1:0] color_ff, color_in;
   logic [7:0]                    alpha_ff, alpha_in;
   logic [sabc_pkg::PIX_BITS-1:0] old_rgb;
   logic [sabc_pkg::PIX_BITS-1:0] mix_rgb;
   logic [sabc_pkg::PIX_BITS-1:0] wr_data;
   logic                          rsp_free;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sabc_pkg::ADDR_BITS-1:0] rsp_addr_ff, rsp_addr_in;
   logic [sabc_pkg::PIX_BITS-1:0] rsp_rgb_ff, rsp_rgb_in;
   logic                          rsp_final_ff, rsp_final_in;

   assign csr_ready = 1'b1;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            sabc_pkg::REG_OFFSET_X:    cfg_in.offset_x    = csr_data;
            sabc_pkg::REG_OFFSET_Y:    cfg_in.offset_y    = csr_data;
            sabc_pkg::REG_ZOOM_X:      cfg_in.zoom_x      = csr_data;
            sabc_pkg::REG_ZOOM_Y:      cfg_in.zoom_y      = csr_data;
            sabc_pkg::REG_CANVAS_COLS: cfg_in.canvas_cols = csr_data[sabc_pkg::LIM_BITS-1:0];
            sabc_pkg::REG_CANVAS_ROWS: cfg_in.canvas_rows = csr_data[sabc_pkg::LIM_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_x    <= '0;
         cfg_ff.offset_y    <= '0;
         cfg_ff.zoom_x      <= 11'd256;
         cfg_ff.zoom_y      <= 11'd256;
         cfg_ff.canvas_cols <= 9'd256;
         cfg_ff.canvas_rows <= 9'd256;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sabc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_src_x (req_src_x),
      .req_src_y (req_src_y),
      .rsp_free  (rsp_free),
      .ctl       (ctl)
   );

   // pixel color held for the whole spot walk
   assign color_in = ctl.load ? {req_src_red, req_src_green, req_src_blue} : color_ff;
   assign alpha_in = ctl.load ? req_src_alpha : alpha_ff;

   always_ff @(posedge clock) begin
      color_ff <= color_in;
      alpha_ff <= alpha_in;
   end

   sabc_blend u_blend (
      .new_rgb (color_ff),
      .old_rgb (old_rgb),
      .alpha   (alpha_ff),
      .mix_rgb (mix_rgb)
   );

   assign wr_data = ctl.clear ? '0 : mix_rgb;

   sabc_ram #(
      .WIDTH (sabc_pkg::PIX_BITS),
      .DEPTH (sabc_pkg::DEPTH)
   ) u_canvas (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .rd_en   (ctl.rd_en),
      .addr    (ctl.addr),
      .wr_data (wr_data),
      .rd_data (old_rgb)
   );

   // output register
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = ctl.emit || (rsp_valid_ff && rsp_stall);
   assign rsp_addr_in  = ctl.emit ? ctl.addr : rsp_addr_ff;
   assign rsp_rgb_in   = ctl.emit ? mix_rgb : rsp_rgb_ff;
   assign rsp_final_in = ctl.emit ? ctl.final_write : rsp_final_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_addr_ff  <= rsp_addr_in;
      rsp_rgb_ff   <= rsp_rgb_in;
      rsp_final_ff <= rsp_final_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_dst_x       = rsp_addr_ff[sabc_pkg::COL_BITS-1:0];
   assign rsp_dst_y       = rsp_addr_ff[sabc_pkg::ADDR_BITS-1:sabc_pkg::COL_BITS];
   assign rsp_out_red     = rsp_rgb_ff[23:16];
   assign rsp_out_green   = rsp_rgb_ff[15:8];
   assign rsp_out_blue    = rsp_rgb_ff[7:0];
   assign rsp_final_write = rsp_final_ff;

endmodule
